// File: design/fvsl_pkg.sv
// Shared types, widths, codes and controller encodings for the file view seek locator.
package fvsl_pkg;

  // Table depth default
  localparam int DEF_TABLE_DEPTH = 64;

  // Field widths
  localparam int OFFSET_W = 32;
  localparam int ELEM_W   = 13;
  localparam int BYTES_W  = OFFSET_W + ELEM_W;  // scaled offset, below 2^45
  localparam int LEN_W    = 32;
  localparam int SLOT_W   = 6;
  localparam int START_W  = 48;
  localparam int DISP_W   = 40;
  localparam int BIU_W    = 7;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 32 + BYTES_W;       // extent times quotient
  localparam int CFG_DW   = 64;
  localparam int CFG_AW   = 6;

  // Divider runs one quotient bit per cycle
  localparam int DIV_STEPS = BYTES_W;
  localparam int DIV_CNT_W = 6;

  localparam logic [START_W-1:0] START_MAX = {START_W{1'b1}};

  // Item kinds carried in tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SEEK = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_VIEW_BYTES    = 3'd0,
    REG_VIEW_EXTENT   = 3'd1,
    REG_VIEW_DISP     = 3'd2,
    REG_ELEMENT_BYTES = 3'd3,
    REG_BLOCKS_IN_USE = 3'd4
  } reg_idx_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_BYTES,
    ST_DIV_LOAD,
    ST_DIV,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD_HI,
    ST_ADD_DISP,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FINISH
  } state_t;

  // Multiplier operand select
  typedef enum logic [1:0] {
    MS_BYTES,
    MS_LO,
    MS_HI
  } mul_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     tbl_wr;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     acc_init;
    logic     acc_add;
    logic     start_calc;
    logic     walk_init;
    logic     walk_rd;
    logic     walk_chk;
    logic     set_err;
    logic     out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic walk_hit;
    logic walk_last;
  } sts_t;

endpackage

// File: design/fvsl_ctrl.sv
// Sequencing state machine for the seek locator: accept, multiply, divide, start, walk, deliver.
module fvsl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  input  logic            view_zero,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  fvsl_pkg::sts_t  sts,
  output fvsl_pkg::cmd_t  cmd
);

  fvsl_pkg::state_t state_r, state_nxt;
  logic [fvsl_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready  = (state_r == fvsl_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // State, step counter and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fvsl_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mul_sel = fvsl_pkg::MS_BYTES;

    case (state_r)
      fvsl_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == fvsl_pkg::KIND_LOAD) begin
            cmd.tbl_wr = 1'b1;
          end else if (!view_zero) begin
            cmd.capture = 1'b1;
            state_nxt   = fvsl_pkg::ST_MUL_BYTES;
          end
        end
      end
      fvsl_pkg::ST_MUL_BYTES: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = fvsl_pkg::MS_BYTES;
        state_nxt   = fvsl_pkg::ST_DIV_LOAD;
      end
      fvsl_pkg::ST_DIV_LOAD: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = fvsl_pkg::ST_DIV;
      end
      fvsl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == fvsl_pkg::DIV_CNT_W'(fvsl_pkg::DIV_STEPS - 1)) begin
          state_nxt = fvsl_pkg::ST_MUL_LO;
        end
      end
      fvsl_pkg::ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = fvsl_pkg::MS_LO;
        state_nxt   = fvsl_pkg::ST_MUL_HI;
      end
      fvsl_pkg::ST_MUL_HI: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = fvsl_pkg::MS_HI;
        cmd.acc_init = 1'b1;
        state_nxt    = fvsl_pkg::ST_ADD_HI;
      end
      fvsl_pkg::ST_ADD_HI: begin
        cmd.acc_add = 1'b1;
        state_nxt   = fvsl_pkg::ST_ADD_DISP;
      end
      fvsl_pkg::ST_ADD_DISP: begin
        cmd.start_calc = 1'b1;
        cmd.walk_init  = 1'b1;
        if (sts.count_zero) begin
          cmd.set_err = 1'b1;
          state_nxt   = fvsl_pkg::ST_FINISH;
        end else begin
          state_nxt = fvsl_pkg::ST_WALK_RD;
        end
      end
      fvsl_pkg::ST_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = fvsl_pkg::ST_WALK_CHK;
      end
      fvsl_pkg::ST_WALK_CHK: begin
        cmd.walk_chk = 1'b1;
        if (sts.walk_hit && sts.walk_last) begin
          cmd.set_err = 1'b1;
          state_nxt   = fvsl_pkg::ST_FINISH;
        end else if (sts.walk_hit) begin
          state_nxt = fvsl_pkg::ST_WALK_RD;
        end else begin
          state_nxt = fvsl_pkg::ST_FINISH;
        end
      end
      fvsl_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = fvsl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fvsl_pkg::ST_IDLE;
      end
    endcase

    // Result valid: set on load, cleared on transfer
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

// File: design/fvsl_dpath.sv
// Datapath: shared multiplier, bit-serial divider, start computation, block table and walk.
module fvsl_dpath #(
  parameter int TABLE_DEPTH = fvsl_pkg::DEF_TABLE_DEPTH
) (
  input  logic                          clk,
  input  fvsl_pkg::cmd_t                cmd,
  output fvsl_pkg::sts_t                sts,
  input  logic [fvsl_pkg::SLOT_W-1:0]   in_slot,
  input  logic [fvsl_pkg::LEN_W-1:0]    in_length,
  input  logic [fvsl_pkg::OFFSET_W-1:0] in_offset,
  input  logic [31:0]                   view_extent,
  input  logic [31:0]                   view_bytes,
  input  logic [fvsl_pkg::DISP_W-1:0]   view_disp,
  input  logic [fvsl_pkg::ELEM_W-1:0]   element_bytes,
  input  logic [fvsl_pkg::BIU_W-1:0]    blocks_in_use,
  output logic [fvsl_pkg::START_W-1:0]  copy_start,
  output logic [31:0]                   bytes_into_copy,
  output logic [5:0]                    block_number,
  output logic [31:0]                   block_start,
  output logic                          overflow_flag,
  output logic                          walk_error
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W = 32 + CNT_W;

  // Seek operand and arithmetic registers
  logic [fvsl_pkg::OFFSET_W-1:0] off_r;
  logic [fvsl_pkg::PROD_W-1:0]   prod_r;
  logic [fvsl_pkg::BYTES_W-1:0]  qd_r;
  logic [31:0]                   rem_r;
  logic [fvsl_pkg::ACC_W-1:0]    acc_r;
  logic [fvsl_pkg::START_W-1:0]  start_r;
  logic                          ovf_r;

  // Walk registers
  logic [SUM_W-1:0] sum_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      pos_r;
  logic             err_r;
  logic [31:0]      rd_data_r;

  // Result registers
  logic [fvsl_pkg::START_W-1:0] copy_start_r;
  logic [31:0]                  bytes_r;
  logic [5:0]                   block_number_r;
  logic [31:0]                  block_start_r;
  logic                         ovf_out_r;
  logic                         err_out_r;

  logic [fvsl_pkg::LEN_W-1:0] tbl_mem [TABLE_DEPTH];

  // Combinational terms
  logic [31:0]                  mul_a, mul_b;
  logic [32:0]                  div_shift;
  logic                         div_ge;
  logic [31:0]                  rem_nxt;
  logic [fvsl_pkg::ACC_W:0]     tot;
  logic                         tot_ovf;
  logic [CNT_W-1:0]             count;
  logic [SUM_W-1:0]             sum_nxt;
  logic                         slot_ok;

  // Multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      fvsl_pkg::MS_BYTES: begin
        mul_a = off_r;
        mul_b = 32'(element_bytes);
      end
      fvsl_pkg::MS_LO: begin
        mul_a = view_extent;
        mul_b = qd_r[31:0];
      end
      fvsl_pkg::MS_HI: begin
        mul_a = view_extent;
        mul_b = 32'(qd_r[fvsl_pkg::BYTES_W-1:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Restoring divide step
  assign div_shift = {rem_r, qd_r[fvsl_pkg::BYTES_W-1]};
  assign div_ge    = (div_shift >= {1'b0, view_bytes});
  assign rem_nxt   = div_ge ? 32'(div_shift - {1'b0, view_bytes}) : div_shift[31:0];

  // Start = extent * quotient + displacement, saturated
  assign tot     = {1'b0, acc_r} + (fvsl_pkg::ACC_W + 1)'(view_disp);
  assign tot_ovf = (tot > (fvsl_pkg::ACC_W + 1)'(fvsl_pkg::START_MAX));

  // Block count clamped to the table depth
  always_comb begin
    if (32'(blocks_in_use) > 32'(TABLE_DEPTH)) begin
      count = CNT_W'(TABLE_DEPTH);
    end else begin
      count = CNT_W'(blocks_in_use);
    end
  end

  assign sum_nxt        = sum_r + SUM_W'(rd_data_r);
  assign sts.count_zero = (blocks_in_use == '0);
  assign sts.walk_hit   = (SUM_W'(rem_r) >= sum_nxt);
  assign sts.walk_last  = ((CNT_W'(idx_r) + CNT_W'(1)) >= count);

  assign slot_ok = (32'(in_slot) < 32'(TABLE_DEPTH));

  // Block length table
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && slot_ok) begin
      tbl_mem[IDX_W'(in_slot)] <= in_length;
    end
    if (cmd.walk_rd) begin
      rd_data_r <= tbl_mem[idx_r];
    end
  end

  // Multiply, divide and start registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      off_r <= in_offset;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.div_init) begin
      qd_r  <= prod_r[fvsl_pkg::BYTES_W-1:0];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      qd_r  <= {qd_r[fvsl_pkg::BYTES_W-2:0], div_ge};
      rem_r <= rem_nxt;
    end
    if (cmd.acc_init) begin
      acc_r <= fvsl_pkg::ACC_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {prod_r[fvsl_pkg::BYTES_W-1:0], 32'b0};
    end
    if (cmd.start_calc) begin
      start_r <= tot_ovf ? fvsl_pkg::START_MAX : tot[fvsl_pkg::START_W-1:0];
      ovf_r   <= tot_ovf;
    end
  end

  // Table walk
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      sum_r <= '0;
      idx_r <= '0;
      pos_r <= '0;
    end else if (cmd.walk_chk && sts.walk_hit) begin
      sum_r <= sum_nxt;
      pos_r <= sum_nxt[31:0];
      idx_r <= IDX_W'(CNT_W'(idx_r) + CNT_W'(1));
    end
    if (cmd.set_err) begin
      err_r <= 1'b1;
    end else if (cmd.walk_init) begin
      err_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      copy_start_r   <= start_r;
      bytes_r        <= rem_r;
      block_number_r <= err_r ? 6'd0 : 6'(idx_r);
      block_start_r  <= err_r ? 32'd0 : pos_r;
      ovf_out_r      <= ovf_r;
      err_out_r      <= err_r;
    end
  end

  assign copy_start      = copy_start_r;
  assign bytes_into_copy = bytes_r;
  assign block_number    = block_number_r;
  assign block_start     = block_start_r;
  assign overflow_flag   = ovf_out_r;
  assign walk_error      = err_out_r;

endmodule

// File: design/file_view_seek_locator.sv
// Top level of the file view seek locator: stream ports, register file and the two halves.
//
// A load item writes one block length into the table in the cycle it transfers. A seek item
// passes through the element-size multiply, the one-bit-per-cycle divider (load plus 45
// quotient bits), the forming of the copy start on the shared 32x32 multiplier and the
// displacement adder, a walk of k table entries (k from 0 to 64; 0 when no block is in use)
// on the table's single read port, and the move of the result into the output register.
// The input takes no item while a seek is at work; a finished result waits in the output
// register while the next item transfers. The block table has no reset; every entry a walk
// reaches must have been loaded first. Registers are 64 bits at byte address 8*i.
module file_view_seek_locator #(
  parameter int TABLE_DEPTH = fvsl_pkg::DEF_TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [71:0]                  in_tdata,   // entry_slot[5:0], entry_length[37:6],
                                                   // seek_offset[69:38], zero[71:70]
  input  logic [0:0]                   in_tuser,   // kind[0]
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [119:0]                 out_tdata,  // copy_start[47:0], bytes_into_copy[79:48],
                                                   // block_number[85:80], block_start[117:86],
                                                   // zero[119:118]
  output logic [1:0]                   out_tuser,  // overflow_flag[0], walk_error[1]
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fvsl_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [fvsl_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [fvsl_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  logic [31:0]                  view_bytes_r;
  logic [31:0]                  view_extent_r;
  logic [fvsl_pkg::DISP_W-1:0]  view_disp_r;
  logic [fvsl_pkg::ELEM_W-1:0]  element_bytes_r;
  logic [fvsl_pkg::BIU_W-1:0]   blocks_in_use_r;

  fvsl_pkg::cmd_t   cmd;
  fvsl_pkg::sts_t   sts;
  fvsl_pkg::reg_idx_t reg_idx;
  logic             cfg_wr;

  logic [fvsl_pkg::START_W-1:0] copy_start;
  logic [31:0]                  bytes_into_copy;
  logic [5:0]                   block_number;
  logic [31:0]                  block_start;
  logic                         overflow_flag;
  logic                         walk_error;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = fvsl_pkg::reg_idx_t'(cfg_paddr[5:3]);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_bytes_r    <= '0;
      view_extent_r   <= '0;
      view_disp_r     <= '0;
      element_bytes_r <= fvsl_pkg::ELEM_W'(1);
      blocks_in_use_r <= fvsl_pkg::BIU_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        fvsl_pkg::REG_VIEW_BYTES:    view_bytes_r    <= cfg_pwdata[31:0];
        fvsl_pkg::REG_VIEW_EXTENT:   view_extent_r   <= cfg_pwdata[31:0];
        fvsl_pkg::REG_VIEW_DISP:     view_disp_r     <= cfg_pwdata[fvsl_pkg::DISP_W-1:0];
        fvsl_pkg::REG_ELEMENT_BYTES: element_bytes_r <= cfg_pwdata[fvsl_pkg::ELEM_W-1:0];
        fvsl_pkg::REG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_pwdata[fvsl_pkg::BIU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      fvsl_pkg::REG_VIEW_BYTES:    cfg_prdata = fvsl_pkg::CFG_DW'(view_bytes_r);
      fvsl_pkg::REG_VIEW_EXTENT:   cfg_prdata = fvsl_pkg::CFG_DW'(view_extent_r);
      fvsl_pkg::REG_VIEW_DISP:     cfg_prdata = fvsl_pkg::CFG_DW'(view_disp_r);
      fvsl_pkg::REG_ELEMENT_BYTES: cfg_prdata = fvsl_pkg::CFG_DW'(element_bytes_r);
      fvsl_pkg::REG_BLOCKS_IN_USE: cfg_prdata = fvsl_pkg::CFG_DW'(blocks_in_use_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  fvsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser[0]),
    .view_zero (view_bytes_r == 32'd0),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fvsl_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_slot         (in_tdata[5:0]),
    .in_length       (in_tdata[37:6]),
    .in_offset       (in_tdata[69:38]),
    .view_extent     (view_extent_r),
    .view_bytes      (view_bytes_r),
    .view_disp       (view_disp_r),
    .element_bytes   (element_bytes_r),
    .blocks_in_use   (blocks_in_use_r),
    .copy_start      (copy_start),
    .bytes_into_copy (bytes_into_copy),
    .block_number    (block_number),
    .block_start     (block_start),
    .overflow_flag   (overflow_flag),
    .walk_error      (walk_error)
  );

  // Result packing
  assign out_tdata = {2'b00, block_start, block_number, bytes_into_copy, copy_start};
  assign out_tuser = {walk_error, overflow_flag};

endmodule

// File: design/fvsl_checker.sv
// Port-level checks for the seek locator and the bind that attaches them.
module fvsl_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         cfg_pready
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A saturated start shows all ones
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[47:0] == 48'hFFFF_FFFF_FFFF)
    else $error("overflow flag without saturated start");

  // A failed walk reports block zero at byte zero
  a_walk_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[85:80] == 6'd0 && out_tdata[117:86] == 32'd0)
    else $error("walk error with nonzero block fields");

  // Register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind file_view_seek_locator fvsl_checker u_fvsl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

// File: tb/fvsl_seek_checker.sv
// Scoreboard for the file view seek locator: tracks registers and table, predicts and compares.
`timescale 1ns / 100ps

module fvsl_seek_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [71:0]                   in_tdata,   // entry_slot[5:0], entry_length[37:6],
                                                    // seek_offset[69:38], zero[71:70]
  input  logic [0:0]                    in_tuser,   // kind[0]
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [119:0]                  out_tdata,  // copy_start[47:0],
                                                    // bytes_into_copy[79:48],
                                                    // block_number[85:80],
                                                    // block_start[117:86], zero[119:118]
  input  logic [1:0]                    out_tuser,  // overflow_flag[0], walk_error[1]
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fvsl_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [fvsl_pkg::CFG_DW-1:0]   cfg_pwdata,
  input  logic                          cfg_pready,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_checked,
  output int                            saturated_starts,
  output int                            past_end_walks
);

  typedef struct packed {
    logic [fvsl_pkg::START_W-1:0] copy_start;
    logic [31:0]                  bytes_into_copy;
    logic [fvsl_pkg::SLOT_W-1:0]  block_number;
    logic [31:0]                  block_start;
    logic                         overflow_flag;
    logic                         walk_error;
  } seek_location_t;

  // Shadow copy of the registers and the block table
  logic [31:0]                 view_bytes_q;
  logic [31:0]                 view_extent_q;
  logic [fvsl_pkg::DISP_W-1:0] view_disp_q;
  logic [fvsl_pkg::ELEM_W-1:0] element_bytes_q;
  logic [fvsl_pkg::BIU_W-1:0]  blocks_in_use_q;
  logic [fvsl_pkg::LEN_W-1:0]  block_len [fvsl_pkg::DEF_TABLE_DEPTH];

  seek_location_t expected_locations[$];
  int fail_count;
  int checked_count;
  int saturated_count;
  int past_end_count;

  assign mismatches       = fail_count;
  assign outstanding      = expected_locations.size();
  assign results_checked  = checked_count;
  assign saturated_starts = saturated_count;
  assign past_end_walks   = past_end_count;

  // Where a seek lands in the tiled view, given the current registers and table
  function automatic seek_location_t locate_seek(logic [31:0] offset);
    seek_location_t loc;
    logic [63:0] scaled;
    logic [63:0] quot;
    logic [63:0] room;
    logic [63:0] rem;
    logic [63:0] sum;
    logic [63:0] pos;
    int unsigned count;
    int unsigned idx;
    logic past_end;
    loc    = '0;
    scaled = 64'(offset) * 64'(element_bytes_q);
    quot   = scaled / 64'(view_bytes_q);
    rem    = scaled % 64'(view_bytes_q);
    room   = 64'(fvsl_pkg::START_MAX) - 64'(view_disp_q);
    // copy start saturates instead of wrapping
    if (quot != 0 && 64'(view_extent_q) > room / quot) begin
      loc.copy_start    = fvsl_pkg::START_MAX;
      loc.overflow_flag = 1'b1;
    end else begin
      loc.copy_start = fvsl_pkg::START_W'(64'(view_extent_q) * quot + 64'(view_disp_q));
    end
    // walk the table summing lengths until the remainder falls inside a block
    count    = (blocks_in_use_q > fvsl_pkg::DEF_TABLE_DEPTH) ?
               fvsl_pkg::DEF_TABLE_DEPTH : blocks_in_use_q;
    past_end = (count == 0);
    idx      = 0;
    pos      = '0;
    if (!past_end) begin
      sum = 64'(block_len[0]);
      while (rem >= sum) begin
        pos = sum;
        idx++;
        if (idx >= count) begin
          past_end = 1'b1;
          break;
        end
        sum += 64'(block_len[idx]);
      end
    end
    if (past_end) begin
      idx = 0;
      pos = '0;
    end
    loc.bytes_into_copy = rem[31:0];
    loc.block_number    = fvsl_pkg::SLOT_W'(idx);
    loc.block_start     = pos[31:0];
    loc.walk_error      = past_end;
    return loc;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    seek_location_t want;
    seek_location_t seen;
    if (!rst_n) begin
      view_bytes_q    = '0;
      view_extent_q   = '0;
      view_disp_q     = '0;
      element_bytes_q = fvsl_pkg::ELEM_W'(1);
      blocks_in_use_q = fvsl_pkg::BIU_W'(1);
      expected_locations.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (fvsl_pkg::reg_idx_t'(cfg_paddr[5:3]))
          fvsl_pkg::REG_VIEW_BYTES:    view_bytes_q    = cfg_pwdata[31:0];
          fvsl_pkg::REG_VIEW_EXTENT:   view_extent_q   = cfg_pwdata[31:0];
          fvsl_pkg::REG_VIEW_DISP:     view_disp_q     = cfg_pwdata[fvsl_pkg::DISP_W-1:0];
          fvsl_pkg::REG_ELEMENT_BYTES: element_bytes_q = cfg_pwdata[fvsl_pkg::ELEM_W-1:0];
          fvsl_pkg::REG_BLOCKS_IN_USE: blocks_in_use_q = cfg_pwdata[fvsl_pkg::BIU_W-1:0];
          default: ;
        endcase
      end
      // result transfers, checked before this edge's input can add anything
      if (out_tvalid && out_tready) begin
        seen.copy_start      = out_tdata[47:0];
        seen.bytes_into_copy = out_tdata[79:48];
        seen.block_number    = out_tdata[85:80];
        seen.block_start     = out_tdata[117:86];
        seen.overflow_flag   = out_tuser[0];
        seen.walk_error      = out_tuser[1];
        if (expected_locations.size() == 0) begin
          $error("result with nothing pending: copy_start %0h", seen.copy_start);
          fail_count++;
        end else begin
          want = expected_locations.pop_front();
          check_field("copy_start", 64'(want.copy_start), 64'(seen.copy_start));
          check_field("bytes_into_copy", 64'(want.bytes_into_copy),
                      64'(seen.bytes_into_copy));
          check_field("block_number", 64'(want.block_number), 64'(seen.block_number));
          check_field("block_start", 64'(want.block_start), 64'(seen.block_start));
          check_field("overflow_flag", 64'(want.overflow_flag), 64'(seen.overflow_flag));
          check_field("walk_error", 64'(want.walk_error), 64'(seen.walk_error));
          checked_count++;
          if (want.overflow_flag) saturated_count++;
          if (want.walk_error) past_end_count++;
        end
      end
      // input transfers: loads fill the table, seeks queue a location
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == fvsl_pkg::KIND_LOAD) begin
          block_len[in_tdata[5:0]] = in_tdata[37:6];
        end else if (view_bytes_q != 0) begin
          expected_locations.push_back(locate_seek(in_tdata[69:38]));
        end
      end
    end
  end

endmodule

// File: tb/file_view_seek_locator_test.sv
// Top of the file view seek locator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module file_view_seek_locator_test;

  localparam int RANDOM_ITEMS = 750;
  localparam int PHASE_ITEMS  = 125;
  localparam int SETTLE       = 256;   // above the longest seek latency
  localparam int LONG_STALL   = 600;
  localparam int STALL_AT     = 60;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [71:0]                  in_tdata;   // entry_slot[5:0], entry_length[37:6],
                                            // seek_offset[69:38], zero[71:70]
  logic [0:0]                   in_tuser;   // kind[0]
  logic                         out_tvalid;
  logic                         out_tready;
  logic [119:0]                 out_tdata;  // copy_start[47:0], bytes_into_copy[79:48],
                                            // block_number[85:80], block_start[117:86],
                                            // zero[119:118]
  logic [1:0]                   out_tuser;  // overflow_flag[0], walk_error[1]
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [fvsl_pkg::CFG_AW-1:0]  cfg_paddr;
  logic [fvsl_pkg::CFG_DW-1:0]  cfg_pwdata;
  logic [fvsl_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                         cfg_pready;

  int mismatches;
  int outstanding;
  int results_checked;
  int saturated_starts;
  int past_end_walks;

  // stimulus-side knowledge
  int unsigned send_idle;
  int unsigned recv_idle;
  bit          stall_request;
  bit          slot_loaded [fvsl_pkg::DEF_TABLE_DEPTH];
  logic [31:0] cur_view_bytes;
  int unsigned cur_blocks;
  int          loads_sent;
  int          seeks_sent;
  int          settings_applied;

  file_view_seek_locator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  fvsl_seek_checker scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_pready       (cfg_pready),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .saturated_starts (saturated_starts),
    .past_end_walks   (past_end_walks)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("FAIL file_view_seek_locator");
    $finish;
  end

  // result sink: random back-pressure, or one long counted hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_request = 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // one input transfer; called and returns at a falling edge
  task automatic send_item(logic kind, logic [5:0] slot, logic [31:0] length,
                           logic [31:0] offset);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, offset, length, slot};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (kind == fvsl_pkg::KIND_SEEK) seeks_sent++;
    else loads_sent++;
  endtask

  task automatic load_block(logic [5:0] slot, logic [31:0] length);
    slot_loaded[slot] = 1'b1;
    send_item(fvsl_pkg::KIND_LOAD, slot, length, $urandom());
  endtask

  task automatic seek_to(logic [31:0] offset);
    send_item(fvsl_pkg::KIND_SEEK, 6'($urandom_range(0, 63)), $urandom(), offset);
  endtask

  // drop valid, wait for every pending result, then let any ignored seek finish
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(fvsl_pkg::reg_idx_t idx, logic [fvsl_pkg::CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= fvsl_pkg::CFG_AW'(idx) << 3;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
  endtask

  task automatic set_view(logic [31:0] vbytes, logic [31:0] extent, logic [39:0] disp,
                          logic [12:0] elem, logic [6:0] blocks);
    wait_quiet();
    write_reg(fvsl_pkg::REG_VIEW_BYTES, 64'(vbytes));
    write_reg(fvsl_pkg::REG_VIEW_EXTENT, 64'(extent));
    write_reg(fvsl_pkg::REG_VIEW_DISP, 64'(disp));
    write_reg(fvsl_pkg::REG_ELEMENT_BYTES, 64'(elem));
    write_reg(fvsl_pkg::REG_BLOCKS_IN_USE, 64'(blocks));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cur_view_bytes = vbytes;
    cur_blocks     = (blocks > fvsl_pkg::DEF_TABLE_DEPTH) ? fvsl_pkg::DEF_TABLE_DEPTH : blocks;
    settings_applied++;
  endtask

  // a seek may only walk entries that were loaded
  function automatic int first_unloaded();
    for (int i = 0; i < cur_blocks; i++)
      if (!slot_loaded[i]) return i;
    return -1;
  endfunction

  // lengths scaled so the loaded blocks roughly tile one view copy
  function automatic logic [31:0] pick_length();
    logic [63:0] cap;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    cap  = 64'(cur_view_bytes) * 2 / ((cur_blocks == 0) ? 1 : cur_blocks);
    if (cap > 64'hFFFF_FFFF) cap = 64'hFFFF_FFFF;
    if (roll < 5) return '0;
    if (roll < 15) return $urandom();
    return $urandom_range(0, 32'(cap));
  endfunction

  function automatic logic [31:0] pick_offset();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return $urandom_range(0, 1000);
    if (roll < 20) return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    return $urandom();
  endfunction

  function automatic logic [39:0] rand_disp();
    return {8'($urandom_range(0, 255)), 32'($urandom())};
  endfunction

  // register settings for each random phase
  task automatic apply_phase(int ph);
    case (ph)
      0: set_view($urandom_range(1000, 60000), $urandom(), rand_disp(),
                  13'($urandom_range(1, 8)), 7'($urandom_range(1, 64)));
      1: set_view($urandom_range(1, 32'hFFFF_FFFF), 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF,
                  13'd4096, 7'd64);
      2: set_view(32'd1, $urandom(), 40'h0, 13'd1, 7'd1);
      3: set_view($urandom_range(1, 5000), $urandom(), rand_disp(),
                  13'($urandom_range(0, 8191)), 7'd127);
      4: set_view(32'hFFFF_FFFF, $urandom(), rand_disp(), 13'($urandom_range(1, 4096)),
                  7'($urandom_range(1, 64)));
      default: set_view($urandom_range(1, 1_000_000), $urandom_range(0, 1000), rand_disp(),
                        13'($urandom_range(1, 4096)), 7'($urandom_range(1, 64)));
    endcase
  endtask

  initial begin
    int slot;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    send_idle     = 0;
    recv_idle     = 0;
    stall_request = 1'b0;
    cur_view_bytes = '0;
    cur_blocks    = 1;
    loads_sent    = 0;
    seeks_sent    = 0;
    settings_applied = 0;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero view size after reset, seek is dropped
    seek_to(32'hFFFF_FFFF);

    // small table, an empty first block, seeks into blocks 1 and 3, later copies
    set_view(32'd100, 32'd1000, 40'h0, 13'd1, 7'd4);
    load_block(6'd0, 32'd0);
    load_block(6'd1, 32'd10);
    load_block(6'd2, 32'd40);
    load_block(6'd3, 32'd50);
    load_block(6'd63, 32'hFFFF_FFFF);
    seek_to(32'd0);
    seek_to(32'd5);
    seek_to(32'd55);
    seek_to(32'd99);
    seek_to(32'd250);

    // remainder past the loaded blocks
    set_view(32'd200, 32'd1000, 40'h12345, 13'd1, 7'd4);
    seek_to(32'd150);
    seek_to(32'd199);

    // no blocks in use: every walk fails
    set_view(32'd100, 32'd1000, 40'h0, 13'd1, 7'd0);
    seek_to(32'd7);

    // saturated copy start, and the unsaturated case at offset zero
    set_view(32'd1, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 13'd4096, 7'd4);
    seek_to(32'hFFFF_FFFF);
    seek_to(32'd0);

    // widest view and a 4096-byte element
    set_view(32'hFFFF_FFFF, 32'd7, 40'h0, 13'd4096, 7'd4);
    seek_to(32'hFFFF_FFFF);

    // random part: phases of settings, three idling patterns, one long sink stall
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        apply_phase(n / PHASE_ITEMS);
        if (n < RANDOM_ITEMS / 3) begin
          send_idle = 32;
          recv_idle = 77;
        end else if (n < 2 * RANDOM_ITEMS / 3) begin
          send_idle = 77;
          recv_idle = 32;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
      end
      if (n == STALL_AT) stall_request = 1'b1;
      slot = first_unloaded();
      if (slot >= 0) load_block(6'(slot), pick_length());
      else if ($urandom_range(0, 99) < 45) seek_to(pick_offset());
      else load_block(6'($urandom_range(0, 63)), pick_length());
    end

    wait_quiet();
    $display("Sent %0d loads and %0d seeks over %0d register settings.",
             loads_sent, seeks_sent, settings_applied);
    $display("Checked %0d locations: %0d saturated starts, %0d walks past the end.",
             results_checked, saturated_starts, past_end_walks);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS file_view_seek_locator");
    end else begin
      $display("FAIL file_view_seek_locator");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fvsl_pkg.sv
design/fvsl_ctrl.sv
design/fvsl_dpath.sv
design/file_view_seek_locator.sv
design/fvsl_checker.sv
tb/fvsl_seek_checker.sv
tb/file_view_seek_locator_test.sv
